/* sv/srg_pkg.sv */
// shared types, constants, microcode table and modular helpers for the subtractive generator
`default_nettype none
package srg_pkg;

    localparam int VAL_W = 30;
    localparam int PTR_W = 6;
    localparam int CNT_W = 8;
    localparam int UPC_W = 3;

    localparam logic [VAL_W-1:0] MODULUS    = 30'd1000000000;
    localparam logic [VAL_W-1:0] SEED_RESET = 30'd161803398;
    localparam logic [PTR_W-1:0] TBL_LEN    = 6'd55;
    localparam logic [PTR_W-1:0] LAG        = 6'd31;
    localparam logic [PTR_W-1:0] SCATTER    = 6'd21;
    localparam logic [PTR_W-1:0] LAST_SLOT  = 6'd54;

    // loop limits (counter value on the last pass)
    localparam logic [CNT_W-1:0] FILL_LAST = 8'd53;
    localparam logic [CNT_W-1:0] WARM_LAST = 8'd219;

    // step codes
    localparam logic [UPC_W-1:0] S_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] S_FILL0 = 3'd1;
    localparam logic [UPC_W-1:0] S_FILL1 = 3'd2;
    localparam logic [UPC_W-1:0] S_WINIT = 3'd3;
    localparam logic [UPC_W-1:0] S_WRD   = 3'd4;
    localparam logic [UPC_W-1:0] S_WWR   = 3'd5;
    localparam logic [UPC_W-1:0] S_DRD   = 3'd6;
    localparam logic [UPC_W-1:0] S_DWR   = 3'd7;

    // write source
    localparam logic [1:0] WS_NONE  = 2'd0;
    localparam logic [1:0] WS_SEED  = 2'd1;
    localparam logic [1:0] WS_CHAIN = 2'd2;
    localparam logic [1:0] WS_DIFF  = 2'd3;

    // difference chain op
    localparam logic [1:0] CH_HOLD = 2'd0;
    localparam logic [1:0] CH_LOAD = 2'd1;
    localparam logic [1:0] CH_STEP = 2'd2;

    // loop counter op
    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_CLR  = 2'd1;
    localparam logic [1:0] CNT_INC  = 2'd2;

    // jump conditions
    localparam logic [2:0] J_NEXT = 3'd0;
    localparam logic [2:0] J_GOTO = 3'd1;
    localparam logic [2:0] J_IN   = 3'd2;
    localparam logic [2:0] J_CNT  = 3'd3;
    localparam logic [2:0] J_OUT  = 3'd4;

    typedef struct packed {
        logic       rd;
        logic [1:0] wsel;
        logic [1:0] chain;
        logic       ptr_init;
        logic       out_load;
    } dp_ctrl_t;

    typedef struct packed {
        dp_ctrl_t         dp;
        logic [1:0]       cnt_op;
        logic [2:0]       jmp;
        logic [CNT_W-1:0] limit;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic init;
        logic out_busy;
    } dp_status_t;

    function automatic uword_t ucode(input logic [UPC_W-1:0] step);
        uword_t w;
        begin
            w = '0;
            unique case (step)
                S_IDLE:
                begin
                    w.jmp    = J_IN;
                    w.target = S_FILL0;
                end
                S_FILL0:
                begin
                    w.dp.wsel  = WS_SEED;
                    w.dp.chain = CH_LOAD;
                    w.cnt_op   = CNT_CLR;
                    w.jmp      = J_NEXT;
                end
                S_FILL1:
                begin
                    w.dp.wsel  = WS_CHAIN;
                    w.dp.chain = CH_STEP;
                    w.cnt_op   = CNT_INC;
                    w.jmp      = J_CNT;
                    w.limit    = FILL_LAST;
                    w.target   = S_FILL1;
                end
                S_WINIT:
                begin
                    w.dp.ptr_init = 1'b1;
                    w.cnt_op      = CNT_CLR;
                    w.jmp         = J_NEXT;
                end
                S_WRD:
                begin
                    w.dp.rd = 1'b1;
                    w.jmp   = J_NEXT;
                end
                S_WWR:
                begin
                    w.dp.wsel = WS_DIFF;
                    w.cnt_op  = CNT_INC;
                    w.jmp     = J_CNT;
                    w.limit   = WARM_LAST;
                    w.target  = S_WRD;
                end
                S_DRD:
                begin
                    w.dp.rd = 1'b1;
                    w.jmp   = J_NEXT;
                end
                S_DWR:
                begin
                    w.dp.wsel     = WS_DIFF;
                    w.dp.out_load = 1'b1;
                    w.jmp         = J_OUT;
                    w.target      = S_IDLE;
                end
                default:
                begin
                    w.jmp    = J_GOTO;
                    w.target = S_IDLE;
                end
            endcase
            return w;
        end
    endfunction

    // (a - b) mod one billion for a, b below one billion
    function automatic logic [VAL_W-1:0] sub_mod(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] t;
        begin
            if (a >= b)
                t = {1'b0, a} - {1'b0, b};
            else
                t = {1'b0, a} + {1'b0, MODULUS} - {1'b0, b};
            return t[VAL_W-1:0];
        end
    endfunction

    // cyclic advance over 1..55
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        begin
            if (p >= TBL_LEN)
                return 6'd1;
            else
                return p + 6'd1;
        end
    endfunction

endpackage
`default_nettype wire

/* sv/subtractive_random_generator.sv */
// top level of the lagged subtractive random generator, modulus one billion
//
//  channel  direction  signals                        payload
//  in       to block   in_valid, in_ready             reseed
//  out      from block out_valid, out_ready           value
//  config   to block   seed_we                        seed
//
// a draw steps through dispatch (item accepted), read and write; the result register is
//   loaded in the write step once the output register is free
// a table fill (first item after reset or reseed set) runs first: seed write,
//   54 scatter writes, one setup step and 220 read/write warm-up pairs on the table port
// in_ready is high only in the dispatch step; a result waiting on out_ready holds
//   the final step until it is taken, while the next item may already be waiting
// reset sets control and pointers to their start values and the seed register to its
//   default; the table is refilled before its first read
`default_nettype none
module subtractive_random_generator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      seed_we,
    input  wire logic [srg_pkg::VAL_W-1:0] seed,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      reseed,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [srg_pkg::VAL_W-1:0]      value
);

    srg_pkg::dp_ctrl_t   ctrl;
    srg_pkg::dp_status_t status;

    srg_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .reseed   (reseed),
        .status   (status),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    srg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed      (seed),
        .ctrl      (ctrl),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .value     (value)
    );

endmodule
`default_nettype wire

/* sv/srg_sequencer.sv */
// microcode sequencer: step counter, loop counter, control rom and jump logic
`default_nettype none
module srg_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                reseed,
    input  wire srg_pkg::dp_status_t status,
    output logic                     in_ready,
    output srg_pkg::dp_ctrl_t        ctrl
);

    logic [srg_pkg::UPC_W-1:0] upc_reg;
    logic [srg_pkg::UPC_W-1:0] upc_next;
    logic [srg_pkg::CNT_W-1:0] cnt_reg;
    logic [srg_pkg::CNT_W-1:0] cnt_next;
    srg_pkg::uword_t           uw;
    logic                      stall;

    assign uw       = srg_pkg::ucode(upc_reg);
    assign stall    = (uw.jmp == srg_pkg::J_OUT) && status.out_busy;
    assign in_ready = (uw.jmp == srg_pkg::J_IN);
    assign ctrl     = stall ? '0 : uw.dp;

    always_comb
    begin
        unique case (uw.jmp)
            srg_pkg::J_NEXT: upc_next = upc_reg + 3'd1;
            srg_pkg::J_GOTO: upc_next = uw.target;
            srg_pkg::J_IN:
            begin
                if (!in_valid)
                    upc_next = upc_reg;
                else if (reseed || !status.init)
                    upc_next = uw.target;
                else
                    upc_next = srg_pkg::S_DRD;
            end
            srg_pkg::J_CNT:  upc_next = (cnt_reg == uw.limit) ? upc_reg + 3'd1 : uw.target;
            srg_pkg::J_OUT:  upc_next = stall ? upc_reg : uw.target;
            default:         upc_next = srg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        unique case (uw.cnt_op)
            srg_pkg::CNT_CLR: cnt_next = '0;
            srg_pkg::CNT_INC: cnt_next = cnt_reg + 8'd1;
            default:          cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= srg_pkg::S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            upc_reg <= upc_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == srg_pkg::S_FILL1) |-> (cnt_reg <= srg_pkg::FILL_LAST))
        else $error("fill counter overran");
`endif

endmodule
`default_nettype wire

/* sv/srg_datapath.sv */
// lag table memory, index pointers, difference chain, seed and output registers
`default_nettype none
module srg_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       seed_we,
    input  wire logic [srg_pkg::VAL_W-1:0]  seed,
    input  wire srg_pkg::dp_ctrl_t          ctrl,
    input  wire logic                       out_ready,
    output srg_pkg::dp_status_t             status,
    output logic                            out_valid,
    output logic [srg_pkg::VAL_W-1:0]       value
);

    logic [srg_pkg::VAL_W-1:0] mem [0:54];

    logic [srg_pkg::VAL_W-1:0] seed_reg;
    logic [srg_pkg::VAL_W-1:0] seed_red;
    logic [srg_pkg::PTR_W-1:0] ia_reg;
    logic [srg_pkg::PTR_W-1:0] ia_next;
    logic [srg_pkg::PTR_W-1:0] ib_reg;
    logic [srg_pkg::PTR_W-1:0] ib_next;
    logic [srg_pkg::PTR_W-1:0] pos_reg;
    logic [srg_pkg::PTR_W:0]   pos_sum;
    logic [srg_pkg::VAL_W-1:0] cur_reg;
    logic [srg_pkg::VAL_W-1:0] prev_reg;
    logic [srg_pkg::VAL_W-1:0] rd_a_reg;
    logic [srg_pkg::VAL_W-1:0] rd_b_reg;
    logic [srg_pkg::VAL_W-1:0] diff;
    logic [srg_pkg::VAL_W-1:0] value_reg;
    logic                      out_valid_reg;
    logic                      init_reg;
    logic [srg_pkg::PTR_W-1:0] wr_addr;
    logic [srg_pkg::VAL_W-1:0] wr_data;
    logic                      wr_en;

    assign seed_red  = (seed_reg >= srg_pkg::MODULUS) ? seed_reg - srg_pkg::MODULUS : seed_reg;
    assign ia_next   = srg_pkg::advance(ia_reg);
    assign ib_next   = srg_pkg::advance(ib_reg);
    assign diff      = srg_pkg::sub_mod(rd_a_reg, rd_b_reg);
    assign pos_sum   = {1'b0, pos_reg} + {1'b0, srg_pkg::SCATTER};

    assign status.init     = init_reg;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign value           = value_reg;

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = ia_reg - 6'd1;
        wr_data = diff;
        unique case (ctrl.wsel)
            srg_pkg::WS_SEED:
            begin
                wr_addr = srg_pkg::LAST_SLOT;
                wr_data = seed_red;
            end
            srg_pkg::WS_CHAIN:
            begin
                wr_addr = pos_reg - 6'd1;
                wr_data = prev_reg;
            end
            srg_pkg::WS_DIFF:
            begin
                wr_addr = ia_reg - 6'd1;
                wr_data = diff;
            end
            default: wr_en = 1'b0;
        endcase
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (ctrl.rd)
        begin
            rd_a_reg <= mem[ia_next - 6'd1];
            rd_b_reg <= mem[ib_next - 6'd1];
        end
    end

    // difference chain for the scatter fill
    always_ff @(posedge clk)
    begin
        case (ctrl.chain)
            srg_pkg::CH_LOAD:
            begin
                cur_reg  <= seed_red;
                prev_reg <= 30'd1;
                pos_reg  <= srg_pkg::SCATTER;
            end
            srg_pkg::CH_STEP:
            begin
                cur_reg  <= prev_reg;
                prev_reg <= srg_pkg::sub_mod(cur_reg, prev_reg);
                pos_reg  <= (pos_sum >= {1'b0, srg_pkg::TBL_LEN})
                          ? pos_sum[srg_pkg::PTR_W-1:0] - srg_pkg::TBL_LEN
                          : pos_sum[srg_pkg::PTR_W-1:0];
            end
            default:
            begin
                cur_reg  <= cur_reg;
                prev_reg <= prev_reg;
                pos_reg  <= pos_reg;
            end
        endcase
        if (ctrl.out_load)
            value_reg <= diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= srg_pkg::SEED_RESET;
            ia_reg        <= '0;
            ib_reg        <= srg_pkg::LAG;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (seed_we)
                seed_reg <= seed;
            if (ctrl.ptr_init)
            begin
                ia_reg   <= '0;
                ib_reg   <= srg_pkg::LAG;
                init_reg <= 1'b1;
            end
            else if (ctrl.rd)
            begin
                ia_reg <= ia_next;
                ib_reg <= ib_next;
            end
            if (ctrl.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (ia_reg == 6'd0) ? (ib_reg == srg_pkg::LAG)
        : ((ia_reg <= 6'd24) ? (ib_reg == ia_reg + 6'd31) : (ib_reg == ia_reg - 6'd24)))
        else $error("table pointers lost their lag");
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (value_reg < srg_pkg::MODULUS))
        else $error("output value not reduced");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(value_reg)))
        else $error("waiting result overwritten");
    a_chain_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wsel == srg_pkg::WS_CHAIN) |-> (pos_reg >= 6'd1 && pos_reg <= 6'd54))
        else $error("scatter position out of range");
`endif

endmodule
`default_nettype wire

/* verif/tb_subtractive_random_generator.sv */
// self-checking testbench for the lagged subtractive generator with an in-bench draw predictor
module tb_subtractive_random_generator;
    import srg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_ITEMS    = 190;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             seed_we   = 1'b0;
    logic [VAL_W-1:0] seed      = '0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic             reseed    = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [VAL_W-1:0] value;

    // pending reseed flags and expected draws
    bit               reseed_q[$];
    logic [VAL_W-1:0] draw_q[$];

    int  src_idle_pct  = 0;
    int  snk_stall_pct = 0;
    bit  in_taken      = 1'b0;
    bit  hold_req      = 1'b0;
    bit  hold_seen     = 1'b0;
    int  hold_left     = 0;
    int  quiet_cycles  = 0;
    int  err_count     = 0;

    // predictor state; slot k holds table position k+1
    logic [VAL_W-1:0] lag_tbl[55];
    logic [PTR_W-1:0] pos_a      = '0;
    logic [PTR_W-1:0] pos_b      = LAG;
    bit               primed     = 1'b0;
    logic [VAL_W-1:0] seed_word  = SEED_RESET;

    subtractive_random_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (seed_we),
        .seed      (seed),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .reseed    (reseed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value     (value)
    );

    always #4 clk = ~clk;

    function automatic logic [VAL_W-1:0] mod_diff(input logic [VAL_W-1:0] a,
                                                  input logic [VAL_W-1:0] b);
        logic [VAL_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (t[VAL_W])
            t = t + {1'b0, MODULUS};
        return t[VAL_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] step_pos(input logic [PTR_W-1:0] p);
        return (p >= TBL_LEN) ? PTR_W'(1) : p + PTR_W'(1);
    endfunction

    task automatic refill_table();
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] prev;
        logic [VAL_W-1:0] nxt;
        int               pos;
        int               other;
        cur  = seed_word;
        prev = VAL_W'(1);
        if (cur >= MODULUS)
            cur = cur - MODULUS;
        lag_tbl[int'(TBL_LEN) - 1] = cur;
        for (int i = 1; i < int'(TBL_LEN); i++)
        begin
            pos = (int'(SCATTER) * i) % int'(TBL_LEN);
            lag_tbl[pos - 1] = prev;
            nxt  = mod_diff(cur, prev);
            cur  = prev;
            prev = nxt;
        end
        for (int pass = 0; pass < 4; pass++)
        begin
            for (int i = 1; i <= int'(TBL_LEN); i++)
            begin
                other = 1 + (i + int'(LAG) - 1) % int'(TBL_LEN);
                lag_tbl[i - 1] = mod_diff(lag_tbl[i - 1], lag_tbl[other - 1]);
            end
        end
        pos_a  = '0;
        pos_b  = LAG;
        primed = 1'b1;
    endtask

    task automatic draw_predict(input bit refill, output logic [VAL_W-1:0] drawn);
        if (refill || !primed)
            refill_table();
        pos_a = step_pos(pos_a);
        pos_b = step_pos(pos_b);
        drawn = mod_diff(lag_tbl[pos_a - 1], lag_tbl[pos_b - 1]);
        lag_tbl[pos_a - 1] = drawn;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (reseed_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    in_valid <= 1'b1;
                    reseed   <= reseed_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen <= hold_req;
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        logic [VAL_W-1:0] drawn;
        logic [VAL_W-1:0] want;
        if (rst_n)
        begin
            if (seed_we)
                seed_word = seed;
            if (out_valid && out_ready)
            begin
                if (draw_q.size() == 0)
                begin
                    $error("value: unexpected item, actual %0d", value);
                    err_count++;
                end
                else
                begin
                    want = draw_q.pop_front();
                    if (value !== want)
                    begin
                        $error("value mismatch: expected %0d, actual %0d", want, value);
                        err_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                draw_predict(reseed, drawn);
                draw_q.push_back(drawn);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            in_taken <= in_valid && in_ready;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic write_seed(input logic [VAL_W-1:0] v);
        @(negedge clk);
        seed_we <= 1'b1;
        seed    <= v;
        @(negedge clk);
        seed_we <= 1'b0;
    endtask

    task automatic queue_bits(input int n, input logic [15:0] bits);
        for (int k = 0; k < n; k++)
            reseed_q.push_back(bits[k]);
    endtask

    task automatic settle();
        while (reseed_q.size() != 0 || in_valid || draw_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] pick_seed();
        if ($urandom_range(7) == 0)
            return VAL_W'($urandom_range(30'h3FFFFFFF, 1000000000));
        return VAL_W'($urandom_range(999999999));
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int k = 0; k < n; k++)
            reseed_q.push_back($urandom_range(9) == 0);
        settle();
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // first draw fills from the reset seed, then a reseed
        queue_bits(6, 16'b010000);
        settle();
        write_seed('0);
        queue_bits(3, 16'b001);
        settle();
        write_seed(VAL_W'(999999999));
        queue_bits(3, 16'b001);
        settle();
        // seeds at and above the modulus
        write_seed(MODULUS);
        queue_bits(2, 16'b01);
        settle();
        write_seed(30'h3FFFFFFF);
        queue_bits(2, 16'b01);
        settle();
        // new seed only takes hold at the next fill
        write_seed(VAL_W'(12345));
        queue_bits(4, 16'b0100);
        settle();

        // output held off while the input keeps offering
        write_seed(pick_seed());
        @(posedge clk);
        hold_req = ~hold_req;
        @(negedge clk);
        for (int k = 0; k < 40; k++)
            reseed_q.push_back($urandom_range(9) == 0);
        settle();

        write_seed(pick_seed());
        run_phase(0, 0, PHASE_ITEMS);
        write_seed(pick_seed());
        run_phase(79, 0, PHASE_ITEMS);
        write_seed(pick_seed());
        run_phase(0, 79, PHASE_ITEMS);
        write_seed(pick_seed());
        run_phase(25, 25, PHASE_ITEMS);

        if (err_count == 0 && draw_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
